FILE: hdl/sml_pkg.sv
// Shared types and constants for the spatial memtable log.
`default_nettype none

package sml_pkg;

  // Fixed field widths of the channel items
  localparam int ID_W        = 64;
  localparam int COORD_W     = 32;
  localparam int THR_W       = 7;
  localparam int COUNT_OUT_W = 7;

  // Reset value of the full threshold register
  localparam logic [THR_W-1:0] THRESH_RESET = 7'd64;

  // Operation codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_GET    = 3'd2,
    MODE_RANGE  = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // Source of the found fields in a result beat
  typedef enum logic [1:0] {
    SEL_PLAIN = 2'd0,
    SEL_ENTRY = 2'd1,
    SEL_PEND  = 2'd2
  } emit_sel_t;

  typedef struct packed {
    logic [2:0]                mode;
    logic [ID_W-1:0]           obj_key;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic                      last;
    logic [ID_W-1:0]           found_id;
    logic signed [COORD_W-1:0] found_min_x;
    logic signed [COORD_W-1:0] found_min_y;
    logic signed [COORD_W-1:0] found_max_x;
    logic signed [COORD_W-1:0] found_max_y;
    logic                      is_tombstone;
    logic [COUNT_OUT_W-1:0]    entry_count;
    logic                      full_res;
  } out_item_t;

  // One stored table entry
  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic                      dead;
  } entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      load_item;
    logic      do_write;
    logic      do_clear;
    logic      start_scan;
    logic      scan_adv;
    logic      push_pend;
    logic      emit;
    emit_sel_t emit_sel;
    status_t   emit_status;
    logic      emit_last;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [2:0] mode;
    logic       table_full;
    logic       scan_done;
    logic       hit;
    logic       pend_valid;
    logic       out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hdl/sml_stream_if.sv
// Valid/ready stream channel carrying one payload per beat.
`default_nettype none

interface sml_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/sml_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, hold when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sml_dp.sv
// Datapath: item register, entry count, entry RAM, scan match logic and result register.
`default_nettype none

module sml_dp #(
  parameter int ENTRIES = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire sml_pkg::in_item_t         in_data,
  input  wire logic                      cfg_valid,
  input  wire logic [sml_pkg::THR_W-1:0] cfg_data,
  output logic                           cfg_ready,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output sml_pkg::out_item_t             out_data,
  input  wire sml_pkg::dp_cmd_t          cmd,
  output sml_pkg::dp_sts_t               sts
);
  import sml_pkg::*;

  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W   = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int ENTRY_W = $bits(entry_t);

  in_item_t          item_r;
  logic [CNT_W-1:0]  count_r,  count_nxt;
  logic [THR_W-1:0]  thresh_r, thresh_nxt;
  logic [ADDR_W-1:0] addr_r,   addr_nxt;
  logic [CNT_W-1:0]  rem_r,    rem_nxt;
  logic              dv_r,     dv_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  entry_t            pend_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r,    out_nxt;

  logic               rd_en;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             rd_entry;
  entry_t             wr_entry;
  logic               tomb_wr;
  logic               get_hit;
  logic               range_hit;
  logic [CMP_W-1:0]   cnt_ext;
  logic               full_flag;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign rd_entry  = entry_t'(rd_data);

  // build the entry to append: a tombstone carries an all-zero rectangle
  assign tomb_wr = (item_r.mode == MODE_DELETE);
  always_comb begin
    wr_entry      = '0;
    wr_entry.id   = item_r.obj_key;
    wr_entry.dead = tomb_wr;
    if (!tomb_wr) begin
      wr_entry.min_x = item_r.min_x;
      wr_entry.min_y = item_r.min_y;
      wr_entry.max_x = item_r.max_x;
      wr_entry.max_y = item_r.max_y;
    end
  end

  // entry store
  assign rd_en = cmd.scan_adv && (rem_r != '0);

  sml_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.do_write),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  // match checks on the entry held in the RAM read data register
  assign get_hit = dv_r && (rd_entry.id == item_r.obj_key);
  assign range_hit = dv_r && !rd_entry.dead &&
                     ($signed(rd_entry.min_x) <= $signed(item_r.max_x)) &&
                     ($signed(item_r.min_x) <= $signed(rd_entry.max_x)) &&
                     ($signed(rd_entry.min_y) <= $signed(item_r.max_y)) &&
                     ($signed(item_r.min_y) <= $signed(rd_entry.max_y));

  always_comb begin
    sts            = '0;
    sts.mode       = item_r.mode;
    sts.table_full = (count_r == CNT_W'(ENTRIES));
    sts.scan_done  = (rem_r == '0) && !dv_r;
    sts.pend_valid = pend_valid_r;
    sts.out_free   = !out_valid_r || out_ready;
    if (item_r.mode == MODE_GET) begin
      sts.hit = get_hit;
    end else if (item_r.mode == MODE_RANGE) begin
      sts.hit = range_hit;
    end
  end

  // entry count and threshold
  always_comb begin
    count_nxt  = count_r;
    thresh_nxt = thresh_r;
    if (cmd.do_clear) begin
      count_nxt = '0;
    end else if (cmd.do_write) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cfg_valid) begin
      thresh_nxt = cfg_data;
    end
  end

  assign cnt_ext   = CMP_W'(count_nxt);
  assign full_flag = (cnt_ext >= CMP_W'(thresh_r));

  // scan address, remaining entries and read-data valid
  always_comb begin
    addr_nxt = addr_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    if (cmd.start_scan) begin
      rem_nxt  = count_r;
      dv_nxt   = 1'b0;
      addr_nxt = (item_r.mode == MODE_GET) ? ADDR_W'(count_r - CNT_W'(1)) : '0;
    end else if (cmd.scan_adv) begin
      dv_nxt = rd_en;
      if (rd_en) begin
        rem_nxt  = rem_r - CNT_W'(1);
        addr_nxt = (item_r.mode == MODE_GET) ? addr_r - ADDR_W'(1) : addr_r + ADDR_W'(1);
      end
    end
  end

  // pending range match, held back until the next one shows whether it is the last
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (cmd.start_scan) begin
      pend_valid_nxt = 1'b0;
    end else if (cmd.push_pend) begin
      pend_valid_nxt = 1'b1;
    end
  end

  // result register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt       = 1'b1;
      out_nxt             = '0;
      out_nxt.status      = cmd.emit_status;
      out_nxt.last        = cmd.emit_last;
      out_nxt.entry_count = cnt_ext[COUNT_OUT_W-1:0];
      out_nxt.full_res    = full_flag;
      unique case (cmd.emit_sel)
        SEL_PLAIN: begin
        end
        SEL_ENTRY: begin
          out_nxt.found_id     = rd_entry.id;
          out_nxt.found_min_x  = rd_entry.min_x;
          out_nxt.found_min_y  = rd_entry.min_y;
          out_nxt.found_max_x  = rd_entry.max_x;
          out_nxt.found_max_y  = rd_entry.max_y;
          out_nxt.is_tombstone = rd_entry.dead;
        end
        SEL_PEND: begin
          out_nxt.found_id    = pend_r.id;
          out_nxt.found_min_x = pend_r.min_x;
          out_nxt.found_min_y = pend_r.min_y;
          out_nxt.found_max_x = pend_r.max_x;
          out_nxt.found_max_y = pend_r.max_y;
        end
        default: begin
        end
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      thresh_r     <= THRESH_RESET;
      rem_r        <= '0;
      dv_r         <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      thresh_r     <= thresh_nxt;
      rem_r        <= rem_nxt;
      dv_r         <= dv_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.push_pend) begin
      pend_r <= rd_entry;
    end
    addr_r <= addr_nxt;
    out_r  <= out_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/sml_ctrl.sv
// Controller: sequences decode, append, scan and result beats of one item at a time.
`default_nettype none

module sml_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sml_pkg::dp_sts_t sts,
  output sml_pkg::dp_cmd_t      cmd
);
  import sml_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      // take a new item
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end

      // single-beat operations complete here, scans are started
      S_DECODE: begin
        unique case (sts.mode)
          MODE_INSERT, MODE_DELETE: begin
            if (sts.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_sel  = SEL_PLAIN;
              cmd.emit_last = 1'b1;
              if (sts.table_full) begin
                cmd.emit_status = ST_FULL;
              end else begin
                cmd.do_write    = 1'b1;
                cmd.emit_status = ST_OK;
              end
              state_nxt = S_IDLE;
            end
          end
          MODE_CLEAR: begin
            if (sts.out_free) begin
              cmd.do_clear    = 1'b1;
              cmd.emit        = 1'b1;
              cmd.emit_sel    = SEL_PLAIN;
              cmd.emit_status = ST_OK;
              cmd.emit_last   = 1'b1;
              state_nxt       = S_IDLE;
            end
          end
          MODE_GET, MODE_RANGE: begin
            cmd.start_scan = 1'b1;
            state_nxt      = S_SCAN;
          end
          default: begin
            if (sts.out_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_sel    = SEL_PLAIN;
              cmd.emit_status = ST_NOMATCH;
              cmd.emit_last   = 1'b1;
              state_nxt       = S_IDLE;
            end
          end
        endcase
      end

      // one entry a cycle; hold while a needed result beat cannot be placed
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_FINISH;
        end else if (!sts.hit) begin
          cmd.scan_adv = 1'b1;
        end else if (sts.mode == MODE_GET) begin
          if (sts.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_sel    = SEL_ENTRY;
            cmd.emit_status = ST_OK;
            cmd.emit_last   = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else if (!sts.pend_valid) begin
          cmd.push_pend = 1'b1;
          cmd.scan_adv  = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_sel    = SEL_PEND;
          cmd.emit_status = ST_OK;
          cmd.emit_last   = 1'b0;
          cmd.push_pend   = 1'b1;
          cmd.scan_adv    = 1'b1;
        end
      end

      // close the item: last range match, or no-match beat
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          if (sts.pend_valid) begin
            cmd.emit_sel    = SEL_PEND;
            cmd.emit_status = ST_OK;
          end else begin
            cmd.emit_sel    = SEL_PLAIN;
            cmd.emit_status = ST_NOMATCH;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/spatial_memtable_log.sv
// Top level of the spatial memtable log: controller, datapath and channel hookup.
//
//   channel  direction  beat contents
//   in_ch    in         mode, obj_key, min_x, min_y, max_x, max_y
//   out_ch   out        status, last, found fields, is_tombstone, entry_count, full_res
//   cfg_ch   in         full_threshold (7 bits)
//
// Insert, delete, clear and unknown modes register their result from the decode state.
// Get and range queries go through decode, then scan one stored entry per cycle through
// the RAM read port with registered read data, then close.
// One item is in work at a time; in_ch is ready again once its last beat is registered.
// A stalled out_ch holds the scan in place on a match that needs a result beat.
// Reset zeroes the count and sets the threshold to 64; the RAM keeps its contents.
`default_nettype none

module spatial_memtable_log #(
  parameter int ENTRIES = 64
) (
  input wire logic   clk,
  input wire logic   rst_n,
  sml_stream_if.sink   in_ch,
  sml_stream_if.source out_ch,
  sml_stream_if.sink   cfg_ch
);
  import sml_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sml_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sml_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cfg_valid (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .cfg_ready (cfg_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

FILE: tb/memtable_checker.sv
// Scoreboard for the spatial memtable log: tracks the table, predicts result beats, compares.
module memtable_checker #(
  parameter int ENTRIES = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  sml_pkg::in_item_t         in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  sml_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [sml_pkg::THR_W-1:0] cfg_data,
  output int unsigned               fail_count,
  output int unsigned               results_due
);
  import sml_pkg::*;

  entry_t           log_mem [ENTRIES];
  int               fill;
  logic [THR_W-1:0] full_at;
  out_item_t        due_q [$];
  int unsigned      n_bad = 0;
  int unsigned      beat_no = 0;

  // Print one line per mismatch and count it
  task automatic report_mismatch(string msg);
    $display("mismatch at result beat %0d: %s", beat_no, msg);
    n_bad++;
  endtask

  task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Build one result beat from an entry and the current count and threshold
  function automatic out_item_t make_beat(status_t st, entry_t e);
    out_item_t r;
    r              = '0;
    r.status       = st;
    r.found_id     = e.id;
    r.found_min_x  = e.min_x;
    r.found_min_y  = e.min_y;
    r.found_max_x  = e.max_x;
    r.found_max_y  = e.max_y;
    r.is_tombstone = e.dead;
    r.entry_count  = COUNT_OUT_W'(fill);
    r.full_res     = (fill >= int'(full_at));
    return r;
  endfunction

  // Apply one accepted command to the table and queue the beats it should produce
  function automatic void apply_command(in_item_t c);
    out_item_t batch [$];
    out_item_t r;
    entry_t    e;
    int        i;
    case (c.mode)
      MODE_INSERT, MODE_DELETE: begin
        if (fill >= ENTRIES) begin
          batch.push_back(make_beat(ST_FULL, '0));
        end else begin
          // a tombstone keeps the id only; its rectangle is zero
          e    = '0;
          e.id = c.obj_key;
          if (c.mode == MODE_INSERT) begin
            e.min_x = c.min_x;
            e.min_y = c.min_y;
            e.max_x = c.max_x;
            e.max_y = c.max_y;
          end else begin
            e.dead = 1'b1;
          end
          log_mem[fill] = e;
          fill++;
          batch.push_back(make_beat(ST_OK, '0));
        end
      end
      MODE_GET: begin
        // newest first, stop at the first id hit
        for (i = fill - 1; i >= 0 && batch.size() == 0; i--)
          if (log_mem[i].id == c.obj_key) batch.push_back(make_beat(ST_OK, log_mem[i]));
        if (batch.size() == 0) batch.push_back(make_beat(ST_NOMATCH, '0));
      end
      MODE_RANGE: begin
        // oldest first, live entries only, inclusive signed overlap
        for (i = 0; i < fill; i++) begin
          e = log_mem[i];
          if (!e.dead &&
              $signed(e.min_x) <= $signed(c.max_x) && $signed(c.min_x) <= $signed(e.max_x) &&
              $signed(e.min_y) <= $signed(c.max_y) && $signed(c.min_y) <= $signed(e.max_y))
            batch.push_back(make_beat(ST_OK, e));
        end
        if (batch.size() == 0) batch.push_back(make_beat(ST_NOMATCH, '0));
      end
      MODE_CLEAR: begin
        fill = 0;
        batch.push_back(make_beat(ST_OK, '0));
      end
      default: begin
        batch.push_back(make_beat(ST_NOMATCH, '0));
      end
    endcase
    // mark the closing beat of this command
    r      = batch.pop_back();
    r.last = 1'b1;
    batch.push_back(r);
    foreach (batch[k]) due_q.push_back(batch[k]);
  endfunction

  // Compare one result beat with the oldest prediction
  task automatic check_beat(out_item_t got);
    out_item_t want;
    if (due_q.size() == 0) begin
      report_mismatch($sformatf("beat with nothing due, status %0d last %0d id %h",
                                got.status, got.last, got.found_id));
    end else begin
      want = due_q.pop_front();
      compare_field("status", 64'(got.status), 64'(want.status));
      compare_field("last", 64'(got.last), 64'(want.last));
      compare_field("found_id", got.found_id, want.found_id);
      compare_field("found_min_x", 64'(got.found_min_x), 64'(want.found_min_x));
      compare_field("found_min_y", 64'(got.found_min_y), 64'(want.found_min_y));
      compare_field("found_max_x", 64'(got.found_max_x), 64'(want.found_max_x));
      compare_field("found_max_y", 64'(got.found_max_y), 64'(want.found_max_y));
      compare_field("is_tombstone", 64'(got.is_tombstone), 64'(want.is_tombstone));
      compare_field("entry_count", 64'(got.entry_count), 64'(want.entry_count));
      compare_field("full_res", 64'(got.full_res), 64'(want.full_res));
    end
    beat_no++;
  endtask

  // Watch all three channels at each edge; publish counts as registers
  always @(posedge clk) begin
    if (!rst_n) begin
      fill    = 0;
      full_at = THRESH_RESET;
      due_q.delete();
    end else begin
      if (out_valid && out_ready) check_beat(out_data);
      if (cfg_valid && cfg_ready) full_at = cfg_data;
      if (in_valid && in_ready) apply_command(in_data);
    end
    fail_count  <= n_bad;
    results_due <= due_q.size();
  end

endmodule

FILE: tb/spatial_memtable_log_tb.sv
// Testbench top for the spatial memtable log: clock, reset, stimulus and verdict.
module spatial_memtable_log_tb;
  import sml_pkg::*;

  localparam int ENTRIES     = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int SPILL_AT    = 150;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 62;
  localparam int CMIN        = 32'sh8000_0000;
  localparam int CMAX        = 32'sh7fff_ffff;

  // Mode codes outside the defined set
  localparam logic [2:0] MODE_RSVD_A = 3'd5;
  localparam logic [2:0] MODE_RSVD_B = 3'd6;
  localparam logic [2:0] MODE_RSVD_C = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        steady;
  int unsigned fail_n;
  int unsigned due_n;

  sml_stream_if #(.payload_t(in_item_t))          in_ch ();
  sml_stream_if #(.payload_t(out_item_t))         out_ch ();
  sml_stream_if #(.payload_t(logic [THR_W-1:0])) cfg_ch ();

  spatial_memtable_log #(.ENTRIES(ENTRIES)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  memtable_checker #(.ENTRIES(ENTRIES)) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_data     (in_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_data    (out_ch.data),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_data    (cfg_ch.data),
    .fail_count  (fail_n),
    .results_due (due_n)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hung block
  initial begin
    #15_000_000;
    $display("spatial_memtable_log test failed");
    $finish;
  end

  function automatic in_item_t cmd(logic [2:0] mode, logic [ID_W-1:0] id,
                                   int ax, int ay, int bx, int by);
    in_item_t c;
    c.mode    = mode;
    c.obj_key = id;
    c.min_x   = ax;
    c.min_y   = ay;
    c.max_x   = bx;
    c.max_y   = by;
    return c;
  endfunction

  // Mostly small ids and rectangles so gets and range queries hit
  function automatic in_item_t random_command(bit allow_clear);
    in_item_t c;
    int       roll;
    int       reach;
    int       x0;
    int       y0;
    c    = '0;
    roll = $urandom_range(0, 99);
    if (roll < 44)                     c.mode = MODE_INSERT;
    else if (roll < 58)                c.mode = MODE_DELETE;
    else if (roll < 74)                c.mode = MODE_GET;
    else if (roll < 88)                c.mode = MODE_RANGE;
    else if (roll < 90 && allow_clear) c.mode = MODE_CLEAR;
    else if (roll < 93)                c.mode = MODE_RSVD_A + 3'($urandom_range(0, 2));
    else                               c.mode = MODE_INSERT;

    roll = $urandom_range(0, 99);
    if (roll < 80)      c.obj_key = 64'($urandom_range(0, 11));
    else if (roll < 88) c.obj_key = {ID_W{roll[0]}};
    else                c.obj_key = {$urandom, $urandom};

    reach = (c.mode == MODE_RANGE) ? 1200 : 300;
    if ($urandom_range(0, 99) < 12) begin
      c.min_x = $urandom;
      c.min_y = $urandom;
      c.max_x = $urandom;
      c.max_y = $urandom;
    end else begin
      x0      = int'($urandom_range(0, 2000)) - 1000;
      y0      = int'($urandom_range(0, 2000)) - 1000;
      c.min_x = x0;
      c.min_y = y0;
      c.max_x = x0 + int'($urandom_range(0, reach));
      c.max_y = y0 + int'($urandom_range(0, reach));
      // now and then turn the rectangle inside out
      if ($urandom_range(0, 99) < 8) begin
        c.min_x = c.max_x;
        c.max_x = x0;
      end
    end
    return c;
  endfunction

  // Offer one command, idling at random first unless steady, and hold until it is taken
  task automatic send_command(in_item_t c);
    if (!steady) begin
      while ($urandom_range(0, 99) < 24) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic set_threshold(logic [THR_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every predicted beat has arrived, pause, then realign to a rising edge
  task automatic wait_idle(int extra);
    @(negedge clk);
    while (due_n != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
    @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off once traffic is flowing
  initial begin : result_sink
    int beats;
    bit held;
    beats = 0;
    held  = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) beats++;
      if (!held && beats >= SPILL_AT) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= rst_n && (steady || $urandom_range(0, 99) >= 24);
      end
    end
  end

  initial begin : stimulus
    in_item_t         plan [$];
    int               ph;
    int               k;
    logic [THR_W-1:0] thr;
    rst_n        <= 1'b0;
    steady       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extremes, tombstones, inclusive edges, unknown modes, clear
    plan.push_back(cmd(MODE_GET, 64'd5, 0, 0, 0, 0));
    plan.push_back(cmd(MODE_RANGE, '0, CMIN, CMIN, CMAX, CMAX));
    plan.push_back(cmd(MODE_INSERT, '0, CMIN, CMIN, CMAX, CMAX));
    plan.push_back(cmd(MODE_INSERT, '1, 100, 100, 200, 200));
    plan.push_back(cmd(MODE_INSERT, 64'h8000_0000_0000_0000, 300, 300, 250, 250));
    plan.push_back(cmd(MODE_INSERT, 64'd7, -200, -200, -100, -100));
    plan.push_back(cmd(MODE_DELETE, '1, 5, 5, 9, 9));
    plan.push_back(cmd(MODE_GET, '1, 0, 0, 0, 0));
    plan.push_back(cmd(MODE_GET, '0, 0, 0, 0, 0));
    plan.push_back(cmd(MODE_GET, 64'h8000_0000_0000_0000, 0, 0, 0, 0));
    plan.push_back(cmd(MODE_GET, 64'd99, 0, 0, 0, 0));
    plan.push_back(cmd(MODE_RANGE, '0, CMIN, CMIN, CMAX, CMAX));
    plan.push_back(cmd(MODE_RANGE, '0, 200, 200, 400, 400));
    plan.push_back(cmd(MODE_RANGE, '0, -100, -100, -100, -100));
    plan.push_back(cmd(MODE_RANGE, '0, CMAX, CMAX, CMIN, CMIN));
    plan.push_back(cmd(MODE_RSVD_A, '1, CMAX, CMIN, -1, 0));
    plan.push_back(cmd(MODE_RSVD_B, 64'h5555_aaaa_5555_aaaa, -1, CMAX, 0, CMIN));
    plan.push_back(cmd(MODE_RSVD_C, '0, 0, 0, 0, 0));
    plan.push_back(cmd(MODE_CLEAR, '0, 0, 0, 0, 0));
    plan.push_back(cmd(MODE_GET, '0, 0, 0, 0, 0));
    plan.push_back(cmd(MODE_RANGE, '0, CMIN, CMIN, CMAX, CMAX));
    plan.push_back(cmd(MODE_INSERT, 64'd7, 10, 10, 20, 20));
    plan.push_back(cmd(MODE_RANGE, '0, 21, 0, 30, 30));
    plan.push_back(cmd(MODE_RANGE, '0, 20, 20, 30, 30));
    foreach (plan[i]) send_command(plan[i]);
    in_ch.valid <= 1'b0;

    // Random phases, each under its own threshold; two middle phases never clear
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle(4);
      case (ph)
        0:       thr = 7'd0;
        1:       thr = 7'd1;
        2:       thr = 7'd64;
        3:       thr = 7'd127;
        4:       thr = 7'd40;
        default: thr = 7'($urandom_range(1, 64));
      endcase
      set_threshold(thr);
      steady <= (ph == 2);
      for (k = 0; k < PHASE_ITEMS; k++)
        send_command(random_command(!(ph == 2 || ph == 3)));
      in_ch.valid <= 1'b0;
    end

    // Drain, let the block settle, then give the verdict
    wait_idle(ENTRIES + 8);
    @(negedge clk);
    if (fail_n == 0) $display("spatial_memtable_log test passed");
    else $display("spatial_memtable_log test failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/sml_pkg.sv
hdl/sml_stream_if.sv
hdl/sml_ram.sv
hdl/sml_dp.sv
hdl/sml_ctrl.sv
hdl/spatial_memtable_log.sv
tb/memtable_checker.sv
tb/spatial_memtable_log_tb.sv
